// ----- hdl/phlt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// phlt_pkg
// Shared types, widths and codes for the page history LRU table.
// ----------------------------------------------------------------------------
package phlt_pkg;

  localparam int ENTRIES    = 256;
  localparam int PAGE_BYTES = 4096;

  localparam int ADDR_W     = 64;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
  localparam int CORE_W     = 12;
  localparam int OUT_PAGE_W = 52;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int CFG_W      = 9;
  localparam int CAPX_W     = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam int TALLY_W    = 32;
  localparam int RATIO_W    = TALLY_W + 4;
  localparam int REG_IDX_W  = 2;

  localparam int S_TDATA_W  = ((ADDR_W + CORE_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((2 + OUT_PAGE_W + CORE_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0]   START_CAP_RESET = CFG_W'(64);
  localparam logic [CFG_W-1:0]   MIN_CAP_RESET   = CFG_W'(16);
  localparam logic [CFG_W-1:0]   MAX_CAP_RESET   = CFG_W'(256);
  localparam logic [TALLY_W:0]   LOOKUP_FLOOR    = (TALLY_W + 1)'(1000);

  localparam logic [REG_IDX_W-1:0] REG_START_CAP = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_MIN_CAP   = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_MAX_CAP   = REG_IDX_W'(2);

  typedef enum logic {
    FUNC_LOOKUP = 1'b0,
    FUNC_ADD    = 1'b1
  } func_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [CORE_W-1:0] core;
  } key_t;

  typedef struct packed {
    logic             shift_all;
    logic             shift_hit;
    logic [IDX_W-1:0] pos;
  } cell_ctrl_t;

  typedef struct packed {
    logic add;
    logic hit;
  } exec_t;

  typedef struct packed {
    logic ready;
    logic exec_go;
    logic evict;
  } ctl_t;

endpackage
`default_nettype wire

// ----- hdl/phlt_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// phlt_cell
// One recency position: holds a key, compares it with the broadcast key and
// takes its neighbor's key when the row shifts.
// ----------------------------------------------------------------------------
module phlt_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [phlt_pkg::IDX_W-1:0] idx_i,
  input  wire logic [phlt_pkg::CNT_W-1:0] count_i,
  input  wire logic                       cmp_en_i,
  input  wire phlt_pkg::key_t             cmp_key_i,
  input  wire phlt_pkg::cell_ctrl_t       ctrl_i,
  input  wire phlt_pkg::key_t             prev_key_i,
  output phlt_pkg::key_t                  key_o,
  output logic                            match_o,
  output phlt_pkg::key_t                  tail_key_o
);
  import phlt_pkg::*;

  key_t key_q, key_d;
  logic match_q, match_d;
  logic live, tail, shift_en;

  assign live     = CNT_W'(idx_i) < count_i;
  assign tail     = (CNT_W'(idx_i) + CNT_W'(1)) == count_i;
  assign shift_en = ctrl_i.shift_all | (ctrl_i.shift_hit & (idx_i <= ctrl_i.pos));

  always_comb begin
    key_d   = shift_en ? prev_key_i : key_q;
    match_d = cmp_en_i ? (live & (key_q == cmp_key_i)) : match_q;
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign key_o      = key_q;
  assign match_o    = match_q;
  assign tail_key_o = tail ? key_q : '0;

endmodule
`default_nettype wire

// ----- hdl/phlt_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// phlt_ctrl
// Request sequencer, entry count, capacity adaptation, hit/miss tallies and
// configuration registers.
// ----------------------------------------------------------------------------
module phlt_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic                           out_free_i,
  input  wire phlt_pkg::exec_t                exec_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [phlt_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [phlt_pkg::CFG_W-1:0]     cfg_data_i,
  output phlt_pkg::ctl_t                      ctl_o,
  output logic [phlt_pkg::CNT_W-1:0]          count_o
);
  import phlt_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [CFG_W-1:0]   cap_q, cap_d;
  logic [CFG_W-1:0]   min_q, min_d;
  logic [CFG_W-1:0]   max_q, max_d;
  logic [TALLY_W-1:0] hits_q, hits_d;
  logic [TALLY_W-1:0] miss_q, miss_d;
  logic               over_q, over_d;
  logic               lo_q, lo_d;
  logic               hi_q, hi_d;

  logic [TALLY_W:0]   total;
  logic [RATIO_W-1:0] h10, t3, t7;
  logic [CAPX_W-1:0]  eff_cap, cap_x, count_x, count_new_x;
  logic [CFG_W:0]     cap_dbl;
  logic [CFG_W-1:0]   cap_half;
  logic               accept, insert, evict;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: if (out_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o = '0;
    unique case (state_q)
      ST_IDLE: ctl_o.ready = 1'b1;
      ST_EXEC: ctl_o.exec_go = out_free_i;
      default: ctl_o = '0;
    endcase
    ctl_o.evict = evict;
  end

  assign accept  = ctl_o.ready & in_valid_i;
  assign insert  = exec_i.add & ~exec_i.hit;

  // tally ratios, settled while the tallies hold
  assign total = (TALLY_W + 1)'(hits_q) + (TALLY_W + 1)'(miss_q);
  assign h10   = (RATIO_W'(hits_q) << 3) + (RATIO_W'(hits_q) << 1);
  assign t3    = (RATIO_W'(total) << 1) + RATIO_W'(total);
  assign t7    = (RATIO_W'(total) << 3) - RATIO_W'(total);

  assign cap_x   = CAPX_W'(cap_q);
  assign count_x = CAPX_W'(count_q);
  always_comb begin
    eff_cap = cap_x;
    if (cap_x < CAPX_W'(1)) eff_cap = CAPX_W'(1);
    if (cap_x > CAPX_W'(ENTRIES)) eff_cap = CAPX_W'(ENTRIES);
  end
  assign evict       = insert & (count_x >= eff_cap);
  assign count_new_x = count_x - CAPX_W'(evict) + CAPX_W'(1);
  assign cap_dbl     = {cap_q, 1'b0};
  assign cap_half    = cap_q >> 1;

  always_comb begin
    count_d = count_q;
    cap_d   = cap_q;
    min_d   = min_q;
    max_d   = max_q;
    hits_d  = hits_q;
    miss_d  = miss_q;
    over_d  = over_q;
    lo_d    = lo_q;
    hi_d    = hi_q;

    if (accept) begin
      over_d = total > LOOKUP_FLOOR;
      lo_d   = h10 < t3;
      hi_d   = h10 > t7;
    end

    if (ctl_o.exec_go) begin
      if (!exec_i.add) begin
        if (exec_i.hit) begin
          if (hits_q != '1) hits_d = hits_q + TALLY_W'(1);
        end else begin
          if (miss_q != '1) miss_d = miss_q + TALLY_W'(1);
        end
      end else if (insert) begin
        count_d = CNT_W'(count_new_x);
        if (over_q) begin
          if (lo_q && (cap_q < max_q)) begin
            cap_d = (cap_dbl > {1'b0, max_q}) ? max_q : cap_dbl[CFG_W-1:0];
          end else if (hi_q && (cap_q > min_q) &&
                       (count_new_x < CAPX_W'(cap_half))) begin
            cap_d = (cap_half < min_q) ? min_q : cap_half;
          end
          hits_d = '0;
          miss_d = '0;
        end
      end
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_CAP: cap_d = cfg_data_i;
        REG_MIN_CAP:   min_d = cfg_data_i;
        REG_MAX_CAP:   max_d = cfg_data_i;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      cap_q   <= START_CAP_RESET;
      min_q   <= MIN_CAP_RESET;
      max_q   <= MAX_CAP_RESET;
      hits_q  <= '0;
      miss_q  <= '0;
      over_q  <= 1'b0;
      lo_q    <= 1'b0;
      hi_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cap_q   <= cap_d;
      min_q   <= min_d;
      max_q   <= max_d;
      hits_q  <= hits_d;
      miss_q  <= miss_d;
      over_q  <= over_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
    end
  end

  assign count_o = count_q;

endmodule
`default_nettype wire

// ----- hdl/page_history_lru_table_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// page_history_lru_table_top
// Recency-ordered table of (4 KiB page, core) keys with LRU eviction and
// capacity that adapts to the lookup hit ratio.
// ----------------------------------------------------------------------------
// When a request is accepted (idle state), every cell of the row compares its
// key with the request and the least recent entry is captured; in the execute
// state the row shifts (move to front or insert) and the result register loads.
// The result register lets the next request enter while a result waits; a
// request stays in the execute state while the result register is still held
// downstream, so a new request is accepted only after the last one has executed.
// ----------------------------------------------------------------------------
module page_history_lru_table_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // byte_address[63:0], core_number[75:64], zero fill
  input  wire logic [phlt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // func[0]
  input  wire logic [0:0]                       s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // hit[0], evicted[1], evicted_page[53:2], evicted_core[65:54], zero fill
  output logic [phlt_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  input  wire logic                             cfg_we_i,
  input  wire logic [phlt_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [phlt_pkg::CFG_W-1:0]       cfg_data_i
);
  import phlt_pkg::*;

  key_t             in_key;
  key_t             key_q, key_d;
  key_t             tail_q, tail_d;
  logic             func_q, func_d;
  key_t             chain [ENTRIES+1];
  key_t             tail_keys [ENTRIES];
  logic [ENTRIES-1:0] match;
  key_t             tail_or;
  logic [IDX_W-1:0] pos;
  logic             hit;
  cell_ctrl_t       cell_ctrl;
  exec_t            exec;
  ctl_t             ctl;
  logic [CNT_W-1:0] count;
  logic             in_fire, out_free;

  logic                  out_valid_q, out_valid_d;
  logic                  out_hit_q, out_hit_d;
  logic                  out_ev_q, out_ev_d;
  logic [OUT_PAGE_W-1:0] out_page_q, out_page_d;
  logic [CORE_W-1:0]     out_core_q, out_core_d;

  assign in_key.page = s_axis_tdata[ADDR_W-1:PAGE_SHIFT];
  assign in_key.core = s_axis_tdata[ADDR_W+CORE_W-1:ADDR_W];
  assign in_fire     = s_axis_tvalid & s_axis_tready;
  assign out_free    = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = ctl.ready;

  assign chain[0] = key_q;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    phlt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (IDX_W'(g)),
      .count_i    (count),
      .cmp_en_i   (in_fire),
      .cmp_key_i  (in_key),
      .ctrl_i     (cell_ctrl),
      .prev_key_i (chain[g]),
      .key_o      (chain[g+1]),
      .match_o    (match[g]),
      .tail_key_o (tail_keys[g])
    );
  end

  always_comb begin
    tail_or = '0;
    pos     = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      tail_or = tail_or | tail_keys[i];
      pos     = pos | (match[i] ? IDX_W'(i) : IDX_W'(0));
    end
  end

  assign hit        = |match;
  assign exec.add   = (func_q == FUNC_ADD);
  assign exec.hit   = hit;

  assign cell_ctrl.shift_all = ctl.exec_go & exec.add & ~hit;
  assign cell_ctrl.shift_hit = ctl.exec_go & hit;
  assign cell_ctrl.pos       = pos;

  phlt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .exec_i     (exec),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctl_o      (ctl),
    .count_o    (count)
  );

  always_comb begin
    key_d       = in_fire ? in_key : key_q;
    func_d      = in_fire ? s_axis_tuser[0] : func_q;
    tail_d      = in_fire ? tail_or : tail_q;
    out_valid_d = out_valid_q;
    out_hit_d   = out_hit_q;
    out_ev_d    = out_ev_q;
    out_page_d  = out_page_q;
    out_core_d  = out_core_q;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    if (ctl.exec_go) begin
      out_valid_d = 1'b1;
      out_hit_d   = hit;
      out_ev_d    = ctl.evict;
      out_page_d  = ctl.evict ? OUT_PAGE_W'(tail_q.page) : '0;
      out_core_d  = ctl.evict ? tail_q.core : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    func_q     <= func_d;
    tail_q     <= tail_d;
    out_hit_q  <= out_hit_d;
    out_ev_q   <= out_ev_d;
    out_page_q <= out_page_d;
    out_core_q <= out_core_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'({out_core_q, out_page_q, out_ev_q, out_hit_q});

`ifndef NO_ASSERTIONS
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl.ready |-> $onehot0(match))
    else $error("more than one live cell matched the request key");

  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.exec_go && ctl.evict |-> !hit && exec.add)
    else $error("eviction requested on a hit or a lookup");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl.exec_go |=> $stable(count))
    else $error("entry count changed outside request execution");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(ENTRIES))
    else $error("entry count exceeds table size");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the page history LRU table.
// Drives lookup and add requests over the input stream and predicts each
// result with a cycle-free copy of the table: recency order, eviction of the
// least recent key and capacity adaptation from the lookup hit ratio.
// Directed cases cover empty lookups, refresh, page aliasing, core mismatch
// and tiny, zero and oversized capacities. Random phases use key pools and
// varying idle and stall patterns. They fill the table past its capacity and
// mix low-hit and high-hit stretches.
// ----------------------------------------------------------------------------
module tb;
  import phlt_pkg::*;

  localparam int          RESET_CYCLES   = 8;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          HOLDOFF_CYCLES = 300;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          REPORT_LIMIT   = 10;
  localparam int          POOL_SIZE      = 32;
  localparam int          MAX_GAP        = 40;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = REG_IDX_W'(3);

  class page_history_ledger;
    typedef struct packed {
      logic                  hit;
      logic                  evicted;
      logic [OUT_PAGE_W-1:0] page;
      logic [CORE_W-1:0]     core;
    } outcome_t;

    bit                  slot_valid [ENTRIES];
    logic [PAGE_W-1:0]   slot_page  [ENTRIES];
    logic [CORE_W-1:0]   slot_core  [ENTRIES];
    int unsigned         order      [ENTRIES];
    int unsigned         live;
    int unsigned         cur_cap;
    int unsigned         min_cap;
    int unsigned         max_cap;
    logic [TALLY_W-1:0]  hits;
    logic [TALLY_W-1:0]  misses;
    outcome_t            pending_outcomes [$];
    int unsigned         mismatches;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_page[i]  = '0;
        slot_core[i]  = '0;
        order[i]      = i;
      end
      live       = 0;
      cur_cap    = START_CAP_RESET;
      min_cap    = MIN_CAP_RESET;
      max_cap    = MAX_CAP_RESET;
      hits       = '0;
      misses     = '0;
      mismatches = 0;
    endfunction

    function void load_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_START_CAP: cur_cap = val;
        REG_MIN_CAP:   min_cap = val;
        REG_MAX_CAP:   max_cap = val;
        default: ;
      endcase
    endfunction

    function outcome_t predict_outcome(func_e op, logic [ADDR_W-1:0] addr,
                                       logic [CORE_W-1:0] core);
      logic [PAGE_W-1:0] page;
      int                pos;
      int unsigned       victim;
      int unsigned       free_slot;
      int unsigned       eff;
      int unsigned       moved;
      longint unsigned   h;
      longint unsigned   tot;
      outcome_t          o;
      page = addr[ADDR_W-1:PAGE_SHIFT];
      o    = '0;
      pos  = -1;
      for (int p = 0; p < live; p++) begin
        if (slot_valid[order[p]] && slot_page[order[p]] == page &&
            slot_core[order[p]] == core) begin
          pos = p;
          break;
        end
      end
      if (pos >= 0) begin
        moved = order[pos];
        for (int q = pos; q > 0; q--) order[q] = order[q-1];
        order[0] = moved;
        o.hit = 1'b1;
      end
      if (op == FUNC_LOOKUP) begin
        if (pos >= 0) begin
          if (hits != '1) hits = hits + 1'b1;
        end else begin
          if (misses != '1) misses = misses + 1'b1;
        end
      end else if (pos < 0) begin
        eff = (cur_cap < 1) ? 1 : (cur_cap > ENTRIES) ? ENTRIES : cur_cap;
        if (live >= eff && live > 0) begin
          victim            = order[live-1];
          o.evicted         = 1'b1;
          o.page            = slot_page[victim];
          o.core            = slot_core[victim];
          slot_valid[victim] = 1'b0;
          live--;
        end
        free_slot = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!slot_valid[i]) begin
            free_slot = i;
            break;
          end
        end
        slot_valid[free_slot] = 1'b1;
        slot_page[free_slot]  = page;
        slot_core[free_slot]  = core;
        for (int i = live; i > 0; i--) order[i] = order[i-1];
        order[0] = free_slot;
        live++;
        h   = hits;
        tot = h + longint'(misses);
        if (tot > LOOKUP_FLOOR) begin
          if (10 * h < 3 * tot && cur_cap < max_cap) begin
            cur_cap = cur_cap * 2;
            if (cur_cap > max_cap) cur_cap = max_cap;
          end else if (10 * h > 7 * tot && cur_cap > min_cap && live < cur_cap / 2) begin
            cur_cap = cur_cap / 2;
            if (cur_cap < min_cap) cur_cap = min_cap;
          end
          hits   = '0;
          misses = '0;
        end
      end
      return o;
    endfunction

    function void note_request(func_e op, logic [ADDR_W-1:0] addr,
                               logic [CORE_W-1:0] core);
      pending_outcomes.push_back(predict_outcome(op, addr, core));
    endfunction

    function void check_outcome(logic [M_TDATA_W-1:0] word);
      outcome_t got;
      outcome_t want;
      got.hit     = word[0];
      got.evicted = word[1];
      got.page    = word[2 +: OUT_PAGE_W];
      got.core    = word[2 + OUT_PAGE_W +: CORE_W];
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: unexpected result hit=%0b evicted=%0b page=%h core=%h",
                   got.hit, got.evicted, got.page, got.core);
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.hit !== want.hit || got.evicted !== want.evicted ||
          got.page !== want.page || got.core !== want.core) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $write("ERROR: result mismatch: expected hit=%0b evicted=%0b page=%h core=%h",
                 want.hit, want.evicted, want.page, want.core);
          $display(" got hit=%0b evicted=%0b page=%h core=%h",
                   got.hit, got.evicted, got.page, got.core);
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_we_i;
  logic [REG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_data_i;

  page_history_ledger    ledger;
  int unsigned           send_idle_pct;
  int unsigned           stall_pct;
  bit                    holdoff_pending;
  logic [PAGE_W-1:0]     pool_page [POOL_SIZE];
  logic [CORE_W-1:0]     pool_core [POOL_SIZE];

  page_history_lru_table_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic pick_idling(input int unsigned k);
    case (k % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 85; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 85; end
      default: begin send_idle_pct = 28; stall_pct = 28; end
    endcase
  endtask

  task automatic refresh_pool();
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_page[k] = (k % 2 == 1) ? pool_page[k-1] : PAGE_W'({$urandom, $urandom});
      pool_core[k] = CORE_W'($urandom);
    end
  endtask

  task automatic offer(input func_e op, input logic [ADDR_W-1:0] addr,
                       input logic [CORE_W-1:0] core);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({core, addr});
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    ledger.note_request(op, addr, core);
  endtask

  task automatic random_run(input int unsigned count, input int unsigned add_pct,
                            input int unsigned pool_pct, input int unsigned pool_n);
    func_e             op;
    logic [ADDR_W-1:0] addr;
    logic [CORE_W-1:0] core;
    int unsigned       k;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) pick_idling(i / 40 + $urandom_range(3));
      op = ($urandom_range(99) < add_pct) ? FUNC_ADD : FUNC_LOOKUP;
      if ($urandom_range(99) < pool_pct) begin
        k    = $urandom_range(pool_n - 1);
        addr = {pool_page[k], PAGE_SHIFT'($urandom)};
        core = pool_core[k];
      end else begin
        addr = {$urandom, $urandom};
        core = CORE_W'($urandom);
      end
      offer(op, addr, core);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (ledger.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    ledger.load_reg(idx, val);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned hold;
    hold = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) ledger.check_outcome(m_axis_tdata);
      if (holdoff_pending) begin
        hold            = HOLDOFF_CYCLES;
        holdoff_pending = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("ERROR: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    ledger          = new();
    send_idle_pct   = 0;
    stall_pct       = 0;
    holdoff_pending = 1'b0;
    rst_ni          <= 1'b0;
    s_axis_tvalid   <= 1'b0;
    s_axis_tdata    <= '0;
    s_axis_tuser    <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_data_i      <= '0;
    refresh_pool();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer(FUNC_LOOKUP, 64'h0, 12'h000);
    offer(FUNC_ADD, 64'h0, 12'h000);
    offer(FUNC_ADD, 64'hFFF, 12'h000);
    offer(FUNC_LOOKUP, 64'h800, 12'h000);
    offer(FUNC_ADD, '1, 12'hFFF);
    offer(FUNC_LOOKUP, '1, 12'h000);
    offer(FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_F000, 12'hFFF);
    offer(FUNC_ADD, 64'h1000, 12'h000);
    offer(FUNC_LOOKUP, 64'h0, 12'hFFF);
    settle();

    program_reg(REG_START_CAP, CFG_W'(1));
    offer(FUNC_ADD, 64'h2000, 12'h001);
    offer(FUNC_ADD, 64'h3000, 12'h001);
    offer(FUNC_ADD, 64'h3ABC, 12'h001);
    offer(FUNC_LOOKUP, 64'h0, 12'h000);
    offer(FUNC_ADD, 64'h4000, 12'h002);
    settle();

    program_reg(REG_START_CAP, CFG_W'(0));
    offer(FUNC_ADD, 64'h5000, 12'h003);
    offer(FUNC_ADD, 64'h6000, 12'h004);
    offer(FUNC_LOOKUP, 64'h6000, 12'h004);
    settle();

    program_reg(REG_START_CAP, '1);
    program_reg(REG_UNUSED, CFG_W'($urandom));
    offer(FUNC_ADD, 64'h7000, 12'h005);
    offer(FUNC_LOOKUP, 64'h4000, 12'h002);
    settle();

    program_reg(REG_START_CAP, CFG_W'(16));
    pick_idling(0);
    holdoff_pending = 1'b1;
    random_run(100, 50, 70, POOL_SIZE);
    settle();

    program_reg(REG_START_CAP, CFG_W'(256));
    program_reg(REG_MAX_CAP, CFG_W'(256));
    random_run(150, 85, 10, POOL_SIZE);
    settle();

    program_reg(REG_START_CAP, CFG_W'(8));
    program_reg(REG_MIN_CAP, CFG_W'(1));
    program_reg(REG_MAX_CAP, CFG_W'(64));
    random_run(200, 10, 20, POOL_SIZE);
    settle();

    refresh_pool();
    program_reg(REG_START_CAP, CFG_W'(128));
    program_reg(REG_MIN_CAP, CFG_W'(4));
    program_reg(REG_MAX_CAP, CFG_W'(256));
    random_run(12, 100, 100, 6);
    random_run(120, 3, 97, 6);
    random_run(4, 100, 0, 6);
    settle();

    program_reg(REG_START_CAP, CFG_W'(256));
    program_reg(REG_MIN_CAP, CFG_W'(256));
    program_reg(REG_MAX_CAP, CFG_W'(1));
    program_reg(REG_UNUSED, CFG_W'($urandom));
    random_run(50, 60, 60, POOL_SIZE);
    settle();

    if (ledger.mismatches == 0 && ledger.pending_outcomes.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
